// ===== hdl/optacc_pkg.sv =====
// Shared types and constants for the outer-product tile accumulator.
// Has no dependencies. The top level imports it; optacc_ram does not.
package optacc_pkg;

	// Default tile size. The top level can override it with its parameters.
	localparam int TILE_ROWS_DEF = 64;
	localparam int TILE_COLS_DEF = 64;

	// Fixed field widths of the stream payload.
	localparam int OPND_W  = 16;
	localparam int SEL_W   = 6;
	localparam int ACC_W   = 48;
	localparam int PROD_W  = 2 * OPND_W;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 48;

	// Request codes carried on s_tuser.
	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_APPLY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	// Control states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_APPLY,
		ST_DRAIN
	} state_t;

endpackage

// ===== hdl/outer_product_tile_accumulator.sv =====
// Outer-product tile accumulator: top level with request decode, apply pipeline and output register.
// Depends on optacc_pkg and optacc_ram.
//
// The block takes one transaction at a time on the slave stream. A load or a clear is done as
// it is taken. A read waits in the read state while a previous result is still waiting on the
// master stream. In an apply the accumulator memory is read and written back one tile row
// per cycle through a three-stage read, multiply, add pipeline, and the next transaction is
// taken once the last write-back is done. There is no clearing pass: a valid bit per tile
// column, cleared at once by reset or a clear request, makes an unwritten column read as zero,
// so the block is ready right after reset.
module outer_product_tile_accumulator
	#(
	parameter int TILE_ROWS = optacc_pkg::TILE_ROWS_DEF,
	parameter int TILE_COLS = optacc_pkg::TILE_COLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Slave stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata, from bit 0 up: operand[15:0], row_sel[21:16], col_sel[27:22], zeros[31:28].
	input  logic [optacc_pkg::S_DATA_W-1:0]  s_tdata,
	// s_tuser, from bit 0 up: req_type[1:0].
	input  logic [1:0]                       s_tuser,
	// Master stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata, from bit 0 up: acc_value[47:0].
	output logic [optacc_pkg::M_DATA_W-1:0]  m_tdata
);

	import optacc_pkg::*;

	localparam int ROW_AW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
	localparam int COL_AW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
	localparam int ROW_XW = (ROW_AW > SEL_W) ? ROW_AW : SEL_W;
	localparam int COL_XW = (COL_AW > SEL_W) ? COL_AW : SEL_W;
	localparam int ACC_AW = ROW_AW + COL_AW;
	localparam int ACC_DEPTH = TILE_COLS << ROW_AW;

	// Payload fields.
	req_t                    req_type;
	logic signed [OPND_W-1:0] operand;
	logic [SEL_W-1:0]        row_sel;
	logic [SEL_W-1:0]        col_sel;
	logic [ROW_XW-1:0]       row_ext;
	logic [COL_XW-1:0]       col_ext;
	logic [ROW_AW-1:0]       row_idx;
	logic [COL_AW-1:0]       col_idx;
	logic                    row_inr;
	logic                    col_inr;

	// Control state.
	state_t                  state_q, state_d;
	logic                    in_xfer;
	logic [ROW_AW-1:0]       row_cnt_q;
	logic [COL_AW-1:0]       apply_col_q;
	logic signed [OPND_W-1:0] op_q;
	logic [TILE_COLS-1:0]    col_vld_q;
	logic                    rd_ok_q;
	logic                    rd_load;

	// Apply pipeline.
	logic                    v_s1, v_s2;
	logic [ROW_AW-1:0]       row_s1, row_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_s2;
	logic signed [ACC_W:0]   sum;
	logic [ACC_W-1:0]        sum_sat;

	// Memory ports.
	logic                    a_we, a_re;
	logic [ROW_AW-1:0]       a_waddr, a_raddr;
	logic [OPND_W-1:0]       a_rdata;
	logic                    acc_we, acc_re;
	logic [ACC_AW-1:0]       acc_waddr, acc_raddr;
	logic [ACC_W-1:0]        acc_rdata;

	// Output register.
	logic                    out_valid_q;
	logic [ACC_W-1:0]        out_data_q;

	// Field unpacking and range checks.
	assign req_type = req_t'(s_tuser);
	assign operand  = s_tdata[OPND_W-1:0];
	assign row_sel  = s_tdata[OPND_W+SEL_W-1:OPND_W];
	assign col_sel  = s_tdata[OPND_W+2*SEL_W-1:OPND_W+SEL_W];
	assign row_ext  = ROW_XW'(row_sel);
	assign col_ext  = COL_XW'(col_sel);
	assign row_idx  = row_ext[ROW_AW-1:0];
	assign col_idx  = col_ext[COL_AW-1:0];
	assign row_inr  = int'(row_sel) < TILE_ROWS;
	assign col_inr  = int'(col_sel) < TILE_COLS;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign rd_load  = (state_q == ST_READ) && (!out_valid_q || m_tready);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d   = state_q;
		a_we      = 1'b0;
		a_waddr   = row_idx;
		a_re      = 1'b0;
		a_raddr   = row_cnt_q;
		acc_re    = 1'b0;
		acc_raddr = {apply_col_q, row_cnt_q};
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (req_type)
						REQ_LOAD: begin
							a_we = row_inr;
						end
						REQ_APPLY: begin
							if (col_inr) begin
								state_d = ST_APPLY;
							end
						end
						REQ_READ: begin
							acc_re    = 1'b1;
							acc_raddr = {col_idx, row_idx};
							state_d   = ST_READ;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				if (rd_load) begin
					state_d = ST_IDLE;
				end
			end
			ST_APPLY: begin
				a_re   = 1'b1;
				acc_re = 1'b1;
				if (row_cnt_q == ROW_AW'(TILE_ROWS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Apply bookkeeping, column valid bits and read qualifier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q   <= '0;
			apply_col_q <= '0;
			col_vld_q   <= '0;
			rd_ok_q     <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && in_xfer) begin
				if (req_type == REQ_APPLY) begin
					row_cnt_q   <= '0;
					apply_col_q <= col_idx;
				end
				if (req_type == REQ_CLEAR) begin
					col_vld_q <= '0;
				end
				if (req_type == REQ_READ) begin
					rd_ok_q <= row_inr && col_inr && col_vld_q[col_idx];
				end
			end
			if (state_q == ST_APPLY) begin
				row_cnt_q <= row_cnt_q + 1'b1;
			end
			if (state_q == ST_DRAIN && !v_s1 && !v_s2) begin
				col_vld_q[apply_col_q] <= 1'b1;
			end
		end
	end

	// The B element is held for the whole walk down the column.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer && req_type == REQ_APPLY) begin
			op_q <= operand;
		end
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_APPLY);
			v_s2 <= v_s1;
		end
	end

	// Stage 1 has the memory data: multiply and pick up the old sum.
	always_ff @(posedge clk) begin
		row_s1  <= row_cnt_q;
		row_s2  <= row_s1;
		prod_s2 <= op_q * signed'(a_rdata);
		acc_s2  <= col_vld_q[apply_col_q] ? signed'(acc_rdata) : '0;
	end

	// Stage 2: add the product and saturate to 48 bits.
	always_comb begin
		sum = (ACC_W+1)'(acc_s2) + (ACC_W+1)'(prod_s2);
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			sum_sat = {sum[ACC_W], {(ACC_W-1){~sum[ACC_W]}}};
		end else begin
			sum_sat = sum[ACC_W-1:0];
		end
	end

	assign acc_we    = v_s2;
	assign acc_waddr = {apply_col_q, row_s2};

	optacc_ram #(
		.WIDTH (OPND_W),
		.DEPTH (TILE_ROWS),
		.AW    (ROW_AW)
	) u_a_buf (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (operand),
		.re    (a_re),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	optacc_ram #(
		.WIDTH (ACC_W),
		.DEPTH (ACC_DEPTH),
		.AW    (ACC_AW)
	) u_acc_mem (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (sum_sat),
		.re    (acc_re),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	// Output register: filled from the read data, emptied by a master transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_load) begin
			out_data_q <= rd_ok_q ? acc_rdata : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef ASSERT_OFF
	// No new transaction is taken while write-backs are still in flight.
	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!v_s1 && !v_s2))
		else $error("slave ready while the apply pipeline is busy");

	// An in-range apply starts the column walk in the next cycle.
	a_apply_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && req_type == REQ_APPLY && col_inr) |=> (state_q == ST_APPLY))
		else $error("apply transaction did not start the column walk");

	// A read transaction always goes through the read state.
	a_read_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && req_type == REQ_READ) |=> (state_q == ST_READ))
		else $error("read transaction did not enter the read state");

	// A write-back follows a stage-1 entry in the previous cycle.
	a_wb_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("write-back without a preceding multiply stage");
`endif

endmodule

// ===== hdl/optacc_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing. Used for the A column buffer and the tile accumulators.
module optacc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
